// ===== rtl/aans_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aans_pkg: shared types and constants for the nearest-neighbor scaler
// Field widths, register indexes, fit-mode codes and the records that travel
// between the setup, front, back and queue parts of the block.
// ----------------------------------------------------------------------------
package aans_pkg;

  localparam int IMG_W      = 13;  // image size registers
  localparam int TGT_W      = 11;  // canvas coordinates and target rectangle
  localparam int SRC_W      = 12;  // source index on the result ports
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Scaled image size: up to 2047 * 8191, fits in 24 bits.
  localparam int DIM_W = IMG_W + TGT_W;
  // Signed image origin on the canvas.
  localparam int POS_W = DIM_W + 1;
  // Numerator of the per-pixel source index division: offset * image size.
  localparam int NUM_W = DIM_W + IMG_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TOP    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = CFG_IDX_W'(6);

  // Fit modes; the unused code behaves as letterbox
  localparam logic [MODE_W-1:0] FIT_STRETCH   = MODE_W'(0);
  localparam logic [MODE_W-1:0] FIT_CROP      = MODE_W'(1);
  localparam logic [MODE_W-1:0] FIT_LETTERBOX = MODE_W'(2);

  // Placement of the drawn image, valid while setup reports ready
  typedef struct packed {
    logic                    none;  // nothing can be covered
    logic [DIM_W-1:0]        dw;
    logic [DIM_W-1:0]        dh;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    logic [IMG_W-1:0]        w;     // clamped image size
    logic [IMG_W-1:0]        h;
  } geom_t;

  // Classified pixel, front to back
  typedef struct packed {
    logic             covered;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
  } mid_t;

  // Result transaction
  typedef struct packed {
    logic             covered;
    logic [SRC_W-1:0] source_x;
    logic [SRC_W-1:0] source_y;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/aans_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aans_fifo: small synchronous queue
// Flop-based first-in first-out buffer with count-derived full and empty.
// ----------------------------------------------------------------------------
module aans_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aans_geom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aans_geom: configuration registers and placement setup
// Holds the registers and, after reset or any register write, works out the
// drawn image size and origin with one serial divider.
// ----------------------------------------------------------------------------
module aans_geom #(
  parameter int IMG_MAX = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [aans_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aans_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              geom_ready,
  output aans_pkg::geom_t                   geom
);
  import aans_pkg::*;

  localparam logic [2:0] ST_MUL  = 3'd0;
  localparam logic [2:0] ST_SEL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int CNT_W = $clog2(DIM_W);
  localparam logic [IMG_W-1:0] IMG_MAX_C = IMG_W'(IMG_MAX);

  logic [2:0]        state;
  logic [IMG_W-1:0]  image_width;
  logic [IMG_W-1:0]  image_height;
  logic [TGT_W-1:0]  target_left;
  logic [TGT_W-1:0]  target_top;
  logic [TGT_W-1:0]  target_width;
  logic [TGT_W-1:0]  target_height;
  logic [MODE_W-1:0] fit_mode;

  logic [IMG_W-1:0]  w_c;
  logic [IMG_W-1:0]  h_c;
  logic [DIM_W-1:0]  p1;        // w * th
  logic [DIM_W-1:0]  p2;        // tw * h
  logic              wider;
  logic [DIM_W-1:0]  div_num;   // numerator, becomes the quotient
  logic [IMG_W-1:0]  div_d;
  logic [IMG_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [IMG_W:0]    trial;
  logic              trial_ge;
  logic              use_h;
  geom_t             g_r;
  geom_t             g_next;

  logic signed [POS_W-1:0] ox_s, oy_s, tw_s, th_s, q_s, diff;

  assign w_c = (image_width == '0) ? IMG_W'(1) :
               (image_width > IMG_MAX_C) ? IMG_MAX_C : image_width;
  assign h_c = (image_height == '0) ? IMG_W'(1) :
               (image_height > IMG_MAX_C) ? IMG_MAX_C : image_height;

  assign trial    = {rem, div_num[DIM_W-1]};
  assign trial_ge = (trial >= {1'b0, div_d});
  assign use_h    = (fit_mode == FIT_CROP) ? (p1 > p2) : !(p1 > p2);

  assign geom_ready = (state == ST_DONE);
  assign geom       = g_r;

  // Final placement from the quotient, or from the target size in stretch mode
  always_comb begin
    ox_s = POS_W'(target_left);
    oy_s = POS_W'(target_top);
    tw_s = POS_W'(target_width);
    th_s = POS_W'(target_height);
    q_s  = POS_W'(div_num);
    diff = '0;
    g_next.w  = w_c;
    g_next.h  = h_c;
    g_next.dw = DIM_W'(target_width);
    g_next.dh = DIM_W'(target_height);
    g_next.bx = ox_s;
    g_next.by = oy_s;
    if (fit_mode == FIT_CROP) begin
      if (wider) begin
        g_next.dw = div_num;
        diff      = q_s - tw_s;
        g_next.bx = ox_s - (diff >>> 1);
      end else begin
        g_next.dh = div_num;
        diff      = q_s - th_s;
        g_next.by = oy_s - (diff >>> 1);
      end
    end else if (fit_mode != FIT_STRETCH) begin
      if (wider) begin
        g_next.dh = div_num;
        diff      = th_s - q_s;
        g_next.by = oy_s + (diff >>> 1);
      end else begin
        g_next.dw = div_num;
        diff      = tw_s - q_s;
        g_next.bx = ox_s + (diff >>> 1);
      end
    end
    g_next.none = (target_width == '0) || (target_height == '0) ||
                  (g_next.dw == '0) || (g_next.dh == '0);
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_MUL: begin
        p1 <= w_c * target_height;
        p2 <= target_width * h_c;
      end
      ST_SEL: begin
        wider   <= (p1 > p2);
        div_num <= use_h ? p1 : p2;
        div_d   <= use_h ? h_c : w_c;
        rem     <= '0;
      end
      ST_DIV: begin
        rem     <= trial_ge ? IMG_W'(trial - {1'b0, div_d}) : trial[IMG_W-1:0];
        div_num <= {div_num[DIM_W-2:0], trial_ge};
      end
      ST_FIN: begin
        g_r <= g_next;
      end
      default: begin
      end
    endcase
  end

  // Registers and setup sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_MUL;
      cnt           <= '0;
      image_width   <= IMG_W'(1);
      image_height  <= IMG_W'(1);
      target_left   <= '0;
      target_top    <= '0;
      target_width  <= TGT_W'(1920);
      target_height <= TGT_W'(1080);
      fit_mode      <= FIT_CROP;
    end else begin
      case (state)
        ST_MUL: state <= ST_SEL;
        ST_SEL: begin
          cnt   <= '0;
          state <= (fit_mode == FIT_STRETCH) ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIM_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN:  state <= ST_DONE;
        ST_DONE: state <= ST_DONE;
        default: state <= ST_MUL;
      endcase
      if (cfg_valid) begin
        state <= ST_MUL;
        case (cfg_index)
          REG_IMAGE_WIDTH:   image_width   <= cfg_data[IMG_W-1:0];
          REG_IMAGE_HEIGHT:  image_height  <= cfg_data[IMG_W-1:0];
          REG_TARGET_LEFT:   target_left   <= cfg_data[TGT_W-1:0];
          REG_TARGET_TOP:    target_top    <= cfg_data[TGT_W-1:0];
          REG_TARGET_WIDTH:  target_width  <= cfg_data[TGT_W-1:0];
          REG_TARGET_HEIGHT: target_height <= cfg_data[TGT_W-1:0];
          REG_FIT_MODE:      fit_mode      <= cfg_data[MODE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aans_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aans_front: pixel intake and coverage test
// Accepts canvas coordinates, tests them against the drawn image and forms
// the numerators of the source index divisions.
// ----------------------------------------------------------------------------
module aans_front #(
  parameter int CANVAS_WIDTH  = 1920,
  parameter int CANVAS_HEIGHT = 1080
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [aans_pkg::TGT_W-1:0]  canvas_x,
  input  logic [aans_pkg::TGT_W-1:0]  canvas_y,
  input  logic                        geom_ready,
  input  aans_pkg::geom_t             geom,
  output logic                        mid_push,
  output aans_pkg::mid_t              mid_data,
  input  logic                        mid_full
);
  import aans_pkg::*;

  logic                  a_valid;
  logic                  a_covered;
  logic [DIM_W-1:0]      a_x;
  logic [DIM_W-1:0]      a_y;
  logic                  hold;
  logic                  accept;
  logic                  on_canvas;
  logic                  x_ok;
  logic                  y_ok;
  logic signed [POS_W:0] x_s;
  logic signed [POS_W:0] y_s;

  assign hold   = a_valid && mid_full;
  assign full   = !geom_ready || hold;
  assign accept = push && !full;

  assign x_s = signed'((POS_W+1)'(canvas_x)) - (POS_W+1)'(geom.bx);
  assign y_s = signed'((POS_W+1)'(canvas_y)) - (POS_W+1)'(geom.by);
  assign x_ok = !x_s[POS_W] && (x_s[POS_W-1:0] < {1'b0, geom.dw});
  assign y_ok = !y_s[POS_W] && (y_s[POS_W-1:0] < {1'b0, geom.dh});
  assign on_canvas = (32'(canvas_x) < CANVAS_WIDTH) && (32'(canvas_y) < CANVAS_HEIGHT);

  assign mid_push         = a_valid && !mid_full;
  assign mid_data.covered = a_covered;
  assign mid_data.num_x   = a_x * geom.w;
  assign mid_data.num_y   = a_y * geom.h;

  always_ff @(posedge clk) begin
    if (accept) begin
      a_covered <= !geom.none && on_canvas && x_ok && y_ok;
      a_x       <= x_s[DIM_W-1:0];
      a_y       <= y_s[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!hold) begin
      a_valid <= accept;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aans_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aans_back: source index dividers
// Two pipelined restoring dividers, one quotient bit per stage, then the
// edge saturation and the result record.
// ----------------------------------------------------------------------------
module aans_back #(
  parameter int QUOT_W = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_empty,
  input  aans_pkg::mid_t    mid_data,
  output logic              mid_pop,
  input  aans_pkg::geom_t   geom,
  input  logic              out_full,
  output logic              out_push,
  output aans_pkg::out_t    out_data
);
  import aans_pkg::*;

  logic                advance;
  logic [QUOT_W:0]     v;
  logic                cov   [QUOT_W+1];
  logic [NUM_W-1:0]    rem_x [QUOT_W+1];
  logic [NUM_W-1:0]    rem_y [QUOT_W+1];
  logic [QUOT_W-1:0]   qx    [QUOT_W+1];
  logic [QUOT_W-1:0]   qy    [QUOT_W+1];
  logic [NUM_W-1:0]    dsx   [QUOT_W];
  logic [NUM_W-1:0]    dsy   [QUOT_W];
  logic [QUOT_W-1:0]   gex;
  logic [QUOT_W-1:0]   gey;
  logic [IMG_W-1:0]    qx_e;
  logic [IMG_W-1:0]    qy_e;
  logic [IMG_W-1:0]    sat_x;
  logic [IMG_W-1:0]    sat_y;

  assign advance = !out_full;
  assign mid_pop = advance && !mid_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[QUOT_W-1:0], mid_pop};
    end
  end

  // Divisor aligned to each stage's quotient bit
  always_comb begin
    for (int i = 0; i < QUOT_W; i++) begin
      dsx[i] = NUM_W'(geom.dw) << (QUOT_W - 1 - i);
      dsy[i] = NUM_W'(geom.dh) << (QUOT_W - 1 - i);
      gex[i] = (rem_x[i] >= dsx[i]);
      gey[i] = (rem_y[i] >= dsy[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cov[0]   <= mid_data.covered;
      rem_x[0] <= mid_data.num_x;
      rem_y[0] <= mid_data.num_y;
      qx[0]    <= '0;
      qy[0]    <= '0;
      for (int i = 0; i < QUOT_W; i++) begin
        cov[i+1]   <= cov[i];
        rem_x[i+1] <= gex[i] ? rem_x[i] - dsx[i] : rem_x[i];
        rem_y[i+1] <= gey[i] ? rem_y[i] - dsy[i] : rem_y[i];
        qx[i+1]    <= QUOT_W'({qx[i], gex[i]});
        qy[i+1]    <= QUOT_W'({qy[i], gey[i]});
      end
    end
  end

  // Saturate at the image edge
  assign qx_e  = IMG_W'(qx[QUOT_W]);
  assign qy_e  = IMG_W'(qy[QUOT_W]);
  assign sat_x = (qx_e >= geom.w) ? geom.w - 1'b1 : qx_e;
  assign sat_y = (qy_e >= geom.h) ? geom.h - 1'b1 : qy_e;

  assign out_push          = advance && v[QUOT_W];
  assign out_data.covered  = cov[QUOT_W];
  assign out_data.source_x = cov[QUOT_W] ? sat_x[SRC_W-1:0] : '0;
  assign out_data.source_y = cov[QUOT_W] ? sat_y[SRC_W-1:0] : '0;

endmodule
`default_nettype wire

// ===== rtl/aspect_aware_nearest_scaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aspect_aware_nearest_scaler: nearest-neighbor image placement on a canvas
// Maps each canvas pixel to the source image pixel drawn on it, or marks it
// uncovered, for stretch, fill-with-crop and fit-with-letterbox modes.
// ----------------------------------------------------------------------------
// Push canvas coordinates in, pop one result per pixel in the same order.
// Sustained rate is one pixel per clock while results are popped and no
// setup runs: a setup unit keeps the placement of the drawn image, a front
// stage tests coverage and forms the products offset * image size, and the
// back end resolves both source indices in two pipelined dividers, one
// quotient bit per stage. After reset and after every register write the
// setup unit recomputes the placement with a serial divider, one bit per
// cycle; full stays high through its multiply, select, divide and finish
// states (no divide in stretch mode). Register writes are always taken
// (cfg_ready is tied high) and belong to idle periods only.
// ----------------------------------------------------------------------------
module aspect_aware_nearest_scaler #(
  parameter int CANVAS_WIDTH  = 1920,
  parameter int CANVAS_HEIGHT = 1080,
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel transactions in
  input  logic                              push,
  output logic                              full,
  input  logic [aans_pkg::TGT_W-1:0]        canvas_x,
  input  logic [aans_pkg::TGT_W-1:0]        canvas_y,
  // result transactions out
  output logic                              empty,
  input  logic                              pop,
  output logic                              covered,
  output logic [aans_pkg::SRC_W-1:0]        source_x,
  output logic [aans_pkg::SRC_W-1:0]        source_y,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aans_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aans_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aans_pkg::*;

  // The image size registers cannot exceed their own width.
  localparam int IMG_MAX = (MAX_IMAGE_DIM > ((1 << IMG_W) - 1)) ?
                           ((1 << IMG_W) - 1) : MAX_IMAGE_DIM;
  // A source index is below the clamped image size.
  localparam int QUOT_W  = (IMG_MAX <= 1) ? 1 : $clog2(IMG_MAX);
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  logic   geom_ready;
  geom_t  geom;
  logic   mid_push;
  mid_t   mid_wr;
  logic   mid_full;
  logic   mid_pop;
  mid_t   mid_rd;
  logic   mid_empty;
  logic   out_push;
  out_t   out_wr;
  logic   out_full;
  out_t   out_rd;

  assign cfg_ready = 1'b1;

  // Setup: registers and image placement
  aans_geom #(
    .IMG_MAX(IMG_MAX)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom_ready(geom_ready),
    .geom      (geom)
  );

  // Front: intake, coverage, numerators
  aans_front #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .canvas_x  (canvas_x),
    .canvas_y  (canvas_y),
    .geom_ready(geom_ready),
    .geom      (geom),
    .mid_push  (mid_push),
    .mid_data  (mid_wr),
    .mid_full  (mid_full)
  );

  // Decoupling queue between front and back
  aans_fifo #(
    .WIDTH($bits(mid_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst    (rst),
    .push   (mid_push),
    .wr_data(mid_wr),
    .full   (mid_full),
    .pop    (mid_pop),
    .rd_data(mid_rd),
    .empty  (mid_empty)
  );

  // Back: source index dividers
  aans_back #(
    .QUOT_W(QUOT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_empty(mid_empty),
    .mid_data (mid_rd),
    .mid_pop  (mid_pop),
    .geom     (geom),
    .out_full (out_full),
    .out_push (out_push),
    .out_data (out_wr)
  );

  // Result queue; its head drives the result ports
  aans_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .push   (out_push),
    .wr_data(out_wr),
    .full   (out_full),
    .pop    (pop),
    .rd_data(out_rd),
    .empty  (empty)
  );

  assign covered  = out_rd.covered;
  assign source_x = out_rd.source_x;
  assign source_y = out_rd.source_y;

  // A register write stalls intake while the placement is recomputed.
  a_cfg_stalls: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> full)
    else $error("intake open right after a register write");

  // An uncovered pixel always carries zero source indices.
  a_uncovered_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !covered) |-> (source_x == '0 && source_y == '0))
    else $error("uncovered result with nonzero source index");

  // The front never writes into a full decoupling queue.
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_full)
    else $error("front pushed into full queue");

  // The back never delivers into a full result queue.
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("back pushed into full result queue");

endmodule
`default_nettype wire
